// ===== sv/rd_pkg.sv =====
package rd_pkg;

    // Field widths fixed by the request format
    localparam int DATA_W   = 8;
    localparam int FILL_W   = 11;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    // Operation codes carried in func
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TOGGLE    = 2'd0,
        FUNC_ADD_FRONT = 2'd1,
        FUNC_ADD_BACK  = 2'd2,
        FUNC_POP       = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL_DROP = 2'd1,
        STATUS_EMPTY_POP = 2'd2
    } t_status;

endpackage

// ===== sv/rd_ram.sv =====
module rd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/reversible_deque_top.sv =====
// Byte deque in a ring buffer of DEPTH entries with a reverse flag that swaps
// the logical front and back. One request is taken per clock cycle (busy stays
// low) and its result appears on the o_ ports in the following cycle, marked
// by o_strobe, high for a single cycle; the receiver cannot stall, so it must
// take every result when the strobe is high. The delay of the read data comes
// from the registered read port of the byte store. The store is not cleared
// at reset and needs no clearing pass: only slots that hold queued bytes are read.
// A push on a full queue is dropped with status 1, a pop on an empty queue
// returns status 2; o_fill_count and o_reversed give the state after the
// request whose result is shown.
module reversible_deque_top #(
    parameter int DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  rd_pkg::t_func                i_func,
    input  logic [rd_pkg::DATA_W-1:0]    i_data_in,
    output logic                         o_strobe,
    output logic [rd_pkg::DATA_W-1:0]    o_data_out,
    output logic                         o_data_valid,
    output rd_pkg::t_status              o_status,
    output logic [rd_pkg::FILL_W-1:0]    o_fill_count,
    output logic                         o_reversed
);

    import rd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Deque state
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_occ, n_occ;
    logic          r_rev, n_rev;

    // Result control
    logic          r_strobe, n_strobe;
    logic          r_valid, n_valid;
    t_status       r_status, n_status;

    // Byte store access
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic          accept;
    logic          full;
    logic          empty;
    logic          at_phys_front;
    logic [SW-1:0] sum_back;
    logic [SW-1:0] sum_last;
    logic [AW-1:0] slot_back;
    logic [AW-1:0] slot_last;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Ring arithmetic: offsets stay below twice the depth (sum_last wraps only when empty, where it is unused)
    always_comb begin
        full     = (r_occ == CW'(DEPTH));
        empty    = (r_occ == '0);
        sum_back = SW'(r_head) + SW'(r_occ);
        sum_last = sum_back - SW'(1);
        if (sum_back >= SW'(DEPTH)) begin
            slot_back = AW'(sum_back - SW'(DEPTH));
        end else begin
            slot_back = AW'(sum_back);
        end
        if (sum_last >= SW'(DEPTH)) begin
            slot_last = AW'(sum_last - SW'(DEPTH));
        end else begin
            slot_last = AW'(sum_last);
        end
        if (r_head == '0) begin
            head_dec = AW'(DEPTH - 1);
        end else begin
            head_dec = r_head - AW'(1);
        end
        if (r_head == AW'(DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = r_head + AW'(1);
        end
        at_phys_front = ((i_func == FUNC_ADD_FRONT) == !r_rev);
    end

    // Decode one request
    always_comb begin
        n_head    = r_head;
        n_occ     = r_occ;
        n_rev     = r_rev;
        n_strobe  = accept;
        n_valid   = 1'b0;
        n_status  = STATUS_OK;
        ram_we    = 1'b0;
        ram_waddr = slot_back;
        ram_re    = 1'b0;
        ram_raddr = r_head;
        if (accept) begin
            case (i_func)
                FUNC_TOGGLE: begin
                    n_rev = !r_rev;
                end
                FUNC_ADD_FRONT, FUNC_ADD_BACK: begin
                    if (full) begin
                        n_status = STATUS_FULL_DROP;
                    end else begin
                        ram_we = 1'b1;
                        n_occ  = r_occ + CW'(1);
                        if (at_phys_front) begin
                            ram_waddr = head_dec;
                            n_head    = head_dec;
                        end
                    end
                end
                FUNC_POP: begin
                    if (empty) begin
                        n_status = STATUS_EMPTY_POP;
                    end else begin
                        ram_re  = 1'b1;
                        n_valid = 1'b1;
                        n_occ   = r_occ - CW'(1);
                        if (r_rev) begin
                            ram_raddr = slot_last;
                        end else begin
                            n_head = head_inc;
                        end
                    end
                end
                default: begin
                    n_status = STATUS_OK;
                end
            endcase
        end
    end

    // Advance state and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_occ    <= '0;
            r_rev    <= 1'b0;
            r_strobe <= 1'b0;
            r_valid  <= 1'b0;
            r_status <= STATUS_OK;
        end else begin
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_rev    <= n_rev;
            r_strobe <= n_strobe;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
    end

    rd_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Drive results; state registers already hold the post-request values
    assign o_strobe     = r_strobe;
    assign o_data_valid = r_valid;
    assign o_data_out   = r_valid ? ram_rdata : '0;
    assign o_status     = r_status;
    assign o_fill_count = FILL_W'(r_occ);
    assign o_reversed   = r_rev;

    // Occupancy never passes the depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH))
        else $error("occupancy above depth");

    // Every request yields one strobe in the next cycle
    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe)
        else $error("missing result strobe");

    // No strobe without a request
    a_no_extra_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_strobe)
        else $error("spurious result strobe");

    // A pop on a non-empty queue returns a byte and shrinks the fill
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_func == FUNC_POP && !empty |=>
            o_data_valid && o_status == STATUS_OK && r_occ == $past(r_occ) - CW'(1))
        else $error("pop did not return a byte");

    // A dropped push leaves the state alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_func == FUNC_ADD_FRONT || i_func == FUNC_ADD_BACK) && full |=>
            o_status == STATUS_FULL_DROP && $stable(r_head) && $stable(r_occ))
        else $error("full push changed state");

endmodule
